FILE: src/assert_macros.svh
// Assertion macros for the checker modules; used by jsc_back.
// No dependencies; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define JSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the house clock and reset names.
`define JSC_ASSERT_STD(lbl, prop, msg) \
  `JSC_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: src/jsc_pkg.sv
// Types and constants of the JSON structure checker.
// No dependencies; used by every module of the block.
package jsc_pkg;

  typedef enum logic [1:0] {
    FUNC_COMMIT  = 2'd0,
    FUNC_PROBE   = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    PM_ROOT   = 3'd0,
    PM_KEY    = 3'd1,
    PM_KEYSTR = 3'd2,
    PM_COLON  = 3'd3,
    PM_VALUE  = 3'd4,
    PM_STRING = 3'd5,
    PM_DELIM  = 3'd6,
    PM_ERROR  = 3'd7
  } pmode_e;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic ws;
    logic open_obj;
    logic open_arr;
    logic close_obj;
    logic close_arr;
    logic quote;
    logic colon;
    logic comma;
    logic bslash;
    logic prim_start;
    logic lit_cont;
  } cls_t;

  typedef struct packed {
    logic [1:0] func;
    logic       first;
    logic       last;
    cls_t       cls;
  } item_t;

  typedef struct packed {
    logic        char_ok;
    logic        token_ok;
    logic        token_done;
    logic        doc_complete;
    logic        in_error;
    logic [5:0]  nest_level;
    logic [31:0] accepted_count;
    logic [31:0] rejected_count;
  } res_t;

endpackage

FILE: src/jsc_front.sv
// Front end: accepts input beats and classifies each character byte.
// Depends on jsc_pkg; feeds jsc_fifo.
module jsc_front (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [7:0]          ch_i,
  input  logic                first_of_token_i,
  input  logic                last_of_token_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output jsc_pkg::item_t      push_data_o
);

  jsc_pkg::cls_t cls;

  always_comb begin
    cls            = '0;
    cls.ws         = ch_i inside {8'h20, 8'h09, 8'h0A, 8'h0D};
    cls.open_obj   = (ch_i == jsc_pkg::CH_LBRACE);
    cls.open_arr   = (ch_i == jsc_pkg::CH_LBRACK);
    cls.close_obj  = (ch_i == jsc_pkg::CH_RBRACE);
    cls.close_arr  = (ch_i == jsc_pkg::CH_RBRACK);
    cls.quote      = (ch_i == jsc_pkg::CH_QUOTE);
    cls.colon      = (ch_i == jsc_pkg::CH_COLON);
    cls.comma      = (ch_i == jsc_pkg::CH_COMMA);
    cls.bslash     = (ch_i == jsc_pkg::CH_BSLASH);
    cls.prim_start = ch_i inside {[8'h30:8'h39], 8'h2D, 8'h74, 8'h66, 8'h6E};
    cls.lit_cont   = ch_i inside {[8'h30:8'h39], 8'h2E, 8'h72, 8'h75, 8'h65,
                                  8'h61, 8'h6C, 8'h73};
  end

  assign push_valid_o       = in_valid_i;
  assign in_ready_o         = push_ready_i;
  assign push_data_o.func   = func_i;
  assign push_data_o.first  = first_of_token_i;
  assign push_data_o.last   = last_of_token_i;
  assign push_data_o.cls    = cls;

endmodule

FILE: src/jsc_fifo.sv
// Short queue of classified beats between front and back end.
// Depends on jsc_pkg for the item type and depth.
module jsc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  jsc_pkg::item_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output jsc_pkg::item_t pop_data_o
);

  localparam int unsigned PTR_W = (jsc_pkg::FIFO_DEPTH > 1) ? $clog2(jsc_pkg::FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(jsc_pkg::FIFO_DEPTH + 1);

  jsc_pkg::item_t mem_q [jsc_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(jsc_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(jsc_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(jsc_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/jsc_back.sv
// Back end: committed and shadow parse contexts, counters, result register.
// Depends on jsc_pkg and assert_macros.svh; fed by jsc_fifo.
`include "assert_macros.svh"

module jsc_back #(
  parameter int unsigned MAX_NEST = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  jsc_pkg::item_t item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jsc_pkg::res_t  res_o
);

  localparam int unsigned DW = $clog2(MAX_NEST + 1);
  localparam int unsigned IW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

  // committed context
  jsc_pkg::pmode_e     live_mode_q, live_mode_d;
  logic [DW-1:0]       live_depth_q, live_depth_d;
  logic [MAX_NEST-1:0] live_stack_q, live_stack_d;
  logic                live_esc_q, live_esc_d;
  logic                live_done_q, live_done_d;
  logic                live_skip_q, live_skip_d;
  // shadow context
  jsc_pkg::pmode_e     sh_mode_q, sh_mode_d;
  logic [DW-1:0]       sh_depth_q, sh_depth_d;
  logic [MAX_NEST-1:0] sh_stack_q, sh_stack_d;
  logic                sh_esc_q, sh_esc_d;
  logic                sh_done_q, sh_done_d;
  logic                sh_skip_q, sh_skip_d;

  logic [31:0] acc_q, acc_d, rej_q, rej_d;

  logic          out_valid_q;
  jsc_pkg::res_t res_q, res_d;
  logic          fire;

  // context the current beat works on
  jsc_pkg::pmode_e     src_mode;
  logic [DW-1:0]       src_depth;
  logic [MAX_NEST-1:0] src_stack;
  logic                src_esc, src_done, src_skip;

  // context after one character
  jsc_pkg::pmode_e     f_mode;
  logic [DW-1:0]       f_depth;
  logic [MAX_NEST-1:0] f_stack;
  logic                f_esc, f_done, f_ok;

  logic [IW-1:0] tix;
  logic          top_bit, depth_nz, can_push, push_req, pop_req;
  jsc_pkg::cls_t cls;
  logic          char_ok, token_ok, token_done, tok_skip;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign cls          = item_i.cls;

  always_comb begin
    src_mode  = live_mode_q;
    src_depth = live_depth_q;
    src_stack = live_stack_q;
    src_esc   = live_esc_q;
    src_done  = live_done_q;
    src_skip  = item_i.first ? 1'b0 : live_skip_q;
    if (item_i.func == jsc_pkg::FUNC_PROBE && !item_i.first) begin
      src_mode  = sh_mode_q;
      src_depth = sh_depth_q;
      src_stack = sh_stack_q;
      src_esc   = sh_esc_q;
      src_done  = sh_done_q;
      src_skip  = sh_skip_q;
    end
  end

  assign tix      = IW'(src_depth - DW'(1));
  assign top_bit  = src_stack[tix];
  assign depth_nz = (src_depth != '0);
  assign can_push = (src_depth < DW'(MAX_NEST));

  always_comb begin
    f_ok     = 1'b0;
    f_mode   = src_mode;
    f_depth  = src_depth;
    f_stack  = src_stack;
    f_esc    = src_esc;
    f_done   = src_done;
    push_req = 1'b0;
    pop_req  = 1'b0;
    if (src_done) begin
      f_ok = cls.ws;
    end else begin
      case (src_mode)
        jsc_pkg::PM_ROOT: begin
          if (cls.ws) f_ok = 1'b1;
          else if (cls.open_obj || cls.open_arr) push_req = 1'b1;
        end
        jsc_pkg::PM_KEY: begin
          if (cls.ws && !src_esc) begin
            f_ok = 1'b1;
          end else if (cls.close_obj && depth_nz && top_bit) begin
            pop_req = 1'b1;
          end else begin
            f_ok = 1'b1;
            if (cls.quote) f_mode = jsc_pkg::PM_KEYSTR;
          end
        end
        jsc_pkg::PM_KEYSTR, jsc_pkg::PM_STRING: begin
          f_ok = 1'b1;
          if (src_esc) begin
            f_esc = 1'b0;
          end else if (cls.bslash) begin
            f_esc = 1'b1;
          end else if (cls.quote) begin
            f_mode = (src_mode == jsc_pkg::PM_KEYSTR) ? jsc_pkg::PM_COLON : jsc_pkg::PM_DELIM;
          end
        end
        jsc_pkg::PM_COLON: begin
          if (cls.ws) begin
            f_ok = 1'b1;
          end else if (cls.colon) begin
            f_ok   = 1'b1;
            f_mode = jsc_pkg::PM_VALUE;
          end
        end
        jsc_pkg::PM_VALUE: begin
          if (cls.ws) begin
            f_ok = 1'b1;
          end else if (cls.open_obj || cls.open_arr) begin
            push_req = 1'b1;
          end else if (cls.close_arr) begin
            pop_req = depth_nz && !top_bit;
          end else if (cls.quote) begin
            f_ok   = 1'b1;
            f_mode = jsc_pkg::PM_STRING;
          end else if (cls.prim_start) begin
            f_ok   = 1'b1;
            f_mode = jsc_pkg::PM_DELIM;
          end
        end
        jsc_pkg::PM_DELIM: begin
          if (cls.ws || cls.lit_cont) begin
            f_ok = 1'b1;
          end else if (cls.comma) begin
            if (depth_nz) begin
              f_ok   = 1'b1;
              f_mode = top_bit ? jsc_pkg::PM_KEY : jsc_pkg::PM_VALUE;
            end
          end else if (cls.close_obj) begin
            pop_req = depth_nz && top_bit;
          end else if (cls.close_arr) begin
            pop_req = depth_nz && !top_bit;
          end
        end
        default: f_ok = 1'b0;
      endcase
    end
    if (push_req && can_push) begin
      f_ok                     = 1'b1;
      f_stack[src_depth[IW-1:0]] = cls.open_obj;
      f_depth                  = src_depth + DW'(1);
      f_mode                   = cls.open_obj ? jsc_pkg::PM_KEY : jsc_pkg::PM_VALUE;
    end
    if (pop_req) begin
      f_ok    = 1'b1;
      f_depth = src_depth - DW'(1);
      f_mode  = jsc_pkg::PM_DELIM;
      if (src_depth == DW'(1)) f_done = 1'b1;
    end
  end

  always_comb begin
    live_mode_d  = live_mode_q;
    live_depth_d = live_depth_q;
    live_stack_d = live_stack_q;
    live_esc_d   = live_esc_q;
    live_done_d  = live_done_q;
    live_skip_d  = live_skip_q;
    sh_mode_d    = sh_mode_q;
    sh_depth_d   = sh_depth_q;
    sh_stack_d   = sh_stack_q;
    sh_esc_d     = sh_esc_q;
    sh_done_d    = sh_done_q;
    sh_skip_d    = sh_skip_q;
    acc_d        = acc_q;
    rej_d        = rej_q;
    char_ok      = 1'b0;
    token_ok     = 1'b0;
    token_done   = 1'b0;
    tok_skip     = src_skip;
    case (item_i.func)
      jsc_pkg::FUNC_COMMIT: begin
        if (!src_skip) begin
          char_ok = f_ok;
          if (f_ok) begin
            live_mode_d  = f_mode;
            live_depth_d = f_depth;
            live_stack_d = f_stack;
            live_esc_d   = f_esc;
            live_done_d  = f_done;
          end else begin
            live_mode_d = jsc_pkg::PM_ERROR;
            tok_skip    = 1'b1;
            rej_d       = rej_q + 32'd1;
          end
        end
        live_skip_d = tok_skip;
        if (item_i.last) begin
          token_done  = 1'b1;
          token_ok    = !tok_skip;
          live_skip_d = 1'b0;
          if (!tok_skip) acc_d = acc_q + 32'd1;
        end
      end
      jsc_pkg::FUNC_PROBE: begin
        sh_mode_d  = src_mode;
        sh_depth_d = src_depth;
        sh_stack_d = src_stack;
        sh_esc_d   = src_esc;
        sh_done_d  = src_done;
        if (!src_skip) begin
          char_ok = f_ok;
          if (f_ok) begin
            sh_mode_d  = f_mode;
            sh_depth_d = f_depth;
            sh_stack_d = f_stack;
            sh_esc_d   = f_esc;
            sh_done_d  = f_done;
          end else begin
            tok_skip = 1'b1;
          end
        end
        sh_skip_d = tok_skip;
        if (item_i.last) begin
          token_done = 1'b1;
          token_ok   = !tok_skip;
        end
      end
      jsc_pkg::FUNC_RESTART: begin
        live_mode_d  = jsc_pkg::PM_ROOT;
        live_depth_d = '0;
        live_stack_d = '0;
        live_esc_d   = 1'b0;
        live_done_d  = 1'b0;
        live_skip_d  = 1'b0;
        sh_mode_d    = jsc_pkg::PM_ROOT;
        sh_depth_d   = '0;
        sh_stack_d   = '0;
        sh_esc_d     = 1'b0;
        sh_done_d    = 1'b0;
        sh_skip_d    = 1'b0;
        acc_d        = '0;
        rej_d        = '0;
      end
      default: ;
    endcase
    res_d.char_ok        = char_ok;
    res_d.token_ok       = token_ok;
    res_d.token_done     = token_done;
    res_d.doc_complete   = live_done_d;
    res_d.in_error       = (live_mode_d == jsc_pkg::PM_ERROR);
    res_d.nest_level     = 6'(live_depth_d);
    res_d.accepted_count = acc_d;
    res_d.rejected_count = rej_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_mode_q  <= jsc_pkg::PM_ROOT;
      live_depth_q <= '0;
      live_stack_q <= '0;
      live_esc_q   <= 1'b0;
      live_done_q  <= 1'b0;
      live_skip_q  <= 1'b0;
      sh_mode_q    <= jsc_pkg::PM_ROOT;
      sh_depth_q   <= '0;
      sh_stack_q   <= '0;
      sh_esc_q     <= 1'b0;
      sh_done_q    <= 1'b0;
      sh_skip_q    <= 1'b0;
      acc_q        <= '0;
      rej_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        live_mode_q  <= live_mode_d;
        live_depth_q <= live_depth_d;
        live_stack_q <= live_stack_d;
        live_esc_q   <= live_esc_d;
        live_done_q  <= live_done_d;
        live_skip_q  <= live_skip_d;
        sh_mode_q    <= sh_mode_d;
        sh_depth_q   <= sh_depth_d;
        sh_stack_q   <= sh_stack_d;
        sh_esc_q     <= sh_esc_d;
        sh_done_q    <= sh_done_d;
        sh_skip_q    <= sh_skip_d;
        acc_q        <= acc_d;
        rej_q        <= rej_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `JSC_ASSERT_STD(a_restart_clears, fire && item_i.func == jsc_pkg::FUNC_RESTART |=> out_valid_q && res_q.nest_level == '0 && res_q.accepted_count == '0 && res_q.rejected_count == '0, "restart left status")
  `JSC_ASSERT_STD(a_tok_ok_done, out_valid_q && res_q.token_ok |-> res_q.token_done, "token verdict without token end")
  `JSC_ASSERT_STD(a_depth_bound, live_depth_q <= DW'(MAX_NEST) && sh_depth_q <= DW'(MAX_NEST), "nesting depth beyond limit")

endmodule

FILE: src/json_structure_checker.sv
// JSON structure checker, top level: front end, queue and back end.
// Depends on jsc_pkg, jsc_front, jsc_fifo and jsc_back.
//
// Takes one character beat per clock while out_ready_i is high and returns one
// result beat per input beat, in order; sustained rate is one beat per cycle
// under that condition. A beat passes the classification queue and then the
// context update (mode step plus one stack bit read or write) in the back end,
// whose result is registered. Commit beats advance the committed context and
// the token counters, probe beats run on the shadow copy, restart clears all.
// The result register holds a result until taken; while one waits, the back
// end takes no new beat, only the queue does. No clearing pass after reset.
module json_structure_checker #(
  parameter int unsigned MAX_NEST = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  ch_i,
  input  logic        first_of_token_i,
  input  logic        last_of_token_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        char_ok_o,
  output logic        token_ok_o,
  output logic        token_done_o,
  output logic        doc_complete_o,
  output logic        in_error_o,
  output logic [5:0]  nest_level_o,
  output logic [31:0] accepted_count_o,
  output logic [31:0] rejected_count_o
);

  logic           push_valid, push_ready, pop_valid, pop_ready;
  jsc_pkg::item_t push_data, pop_data;
  jsc_pkg::res_t  res;

  jsc_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .ch_i             (ch_i),
    .first_of_token_i (first_of_token_i),
    .last_of_token_i  (last_of_token_i),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_data_o      (push_data)
  );

  jsc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  jsc_back #(
    .MAX_NEST (MAX_NEST)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .item_i       (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign char_ok_o        = res.char_ok;
  assign token_ok_o       = res.token_ok;
  assign token_done_o     = res.token_done;
  assign doc_complete_o   = res.doc_complete;
  assign in_error_o       = res.in_error;
  assign nest_level_o     = res.nest_level;
  assign accepted_count_o = res.accepted_count;
  assign rejected_count_o = res.rejected_count;

endmodule
